// ----- hdl/sfs_pkg.sv -----
// Package for the substring find-and-split block: types, register codes, helpers.
`timescale 1ns / 1ps

package sfs_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_W           = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INC_EMPTY = 8'd3;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] first_index;
		logic [31:0] last_index;
		logic [31:0] piece_count;
		logic        too_long;
	} out_item_t;

	// Per-byte control handed from the cell row to the tracker
	typedef struct packed {
		logic             step;
		logic             last;
		logic             match;
		logic [LEN_W-1:0] len;
		logic             incl_empty;
	} trk_ctl_t;

	// Byte k of the pattern, byte 0 in the low bits of the low word
	function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
						    input logic [63:0] hi,
						    input logic [3:0]  k);
		logic [63:0] word;
		word = k[3] ? hi : lo;
		return word[{k[2:0], 3'b000} +: 8];
	endfunction

endpackage

// ----- hdl/substring_find_and_split.sv -----
// Top level of the streaming substring find-and-split block.
`timescale 1ns / 1ps
// Usage:
//   Text enters on the in channel one byte per transfer (in_data.text_byte), with
//   in_data.final_byte set on the last byte of a text. A transfer happens at a
//   rising edge where in_valid is high and in_stall is low.
//   The pattern (1..16 bytes) and include_empty are written on the cfg channel
//   (index 0/1 pattern words, 2 length, 3 include_empty) while no text is open;
//   cfg_ready is always high.
//   One result per text leaves on the out channel: found, first and last match
//   start, split piece count and the too_long flag.
// Timing:
//   One byte per cycle sustained, but a final byte is held while a result waits
//   under out_stall. Every byte passes through the row of window cells, which
//   compare in parallel in the cycle the byte arrives; the position and piece
//   counters update at the same edge. The result is registered and shows in the
//   cycle after the final byte's transfer.
// Stall / reset:
//   The output register parts the two sides. While a result waits under
//   out_stall, ordinary bytes are still taken; only a final byte is held back.
//   Reset clears the window, all per-text state and restores the register
//   defaults (pattern zero, length 1, include_empty 0).

module substring_find_and_split import sfs_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [63:0]      pat_lo_q, pat_hi_q;
	logic [LEN_W-1:0] pat_len_q;
	logic             incl_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
			incl_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAT_LOW:   pat_lo_q  <= cfg_data;
				REG_PAT_HIGH:  pat_hi_q  <= cfg_data;
				REG_PAT_LEN:   pat_len_q <= cfg_data[LEN_W-1:0];
				REG_INC_EMPTY: incl_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Lengths above the cell count are clamped
	logic [LEN_W-1:0] len_used;
	assign len_used = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;

	logic accept;
	assign accept = in_valid && !in_stall;

	// Cell row: cell j holds the byte j+1 positions back and checks the byte j back against
	// pattern byte len-1-j; cells past the length are ignored.
	logic [7:0]             cell_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_ok;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [7:0]       byte_in;
		logic [LEN_W-1:0] pidx;
		logic             active;

		assign active = len_used > LEN_W'(j);
		assign pidx   = len_used - LEN_W'(j + 1);
		if (j == 0) begin : g_head
			assign byte_in = in_data.text_byte;
		end else begin : g_link
			assign byte_in = cell_byte[j-1];
		end

		sfs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift       (accept),
			.byte_in     (byte_in),
			.expect_byte (pattern_byte(pat_lo_q, pat_hi_q, pidx[3:0])),
			.active      (active),
			.byte_out    (cell_byte[j]),
			.ok          (cell_ok[j])
		);
	end

	trk_ctl_t  ctl;
	out_item_t res;

	assign ctl.step       = accept;
	assign ctl.last       = in_data.final_byte;
	assign ctl.match      = &cell_ok;
	assign ctl.len        = len_used;
	assign ctl.incl_empty = incl_q;

	sfs_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.res    (res)
	);

	// Output register; a final byte waits only if a result is stuck here
	logic      out_valid_q;
	out_item_t out_data_q;

	assign in_stall = out_valid_q && out_stall && in_data.final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && in_data.final_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.final_byte) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.first_index == '0 &&
			out_data.last_index == '0)
		else $error("index nonzero without a match");

	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.found |-> out_data.first_index <= out_data.last_index)
		else $error("first match after last match");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held without a pending result");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.final_byte |=> out_valid)
		else $error("final byte produced no result");

endmodule

// ----- hdl/sfs_cell.sv -----
// One window cell: holds a text byte, passes it on, compares the incoming byte.
`timescale 1ns / 1ps

module sfs_cell import sfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] byte_in,
	input  logic [7:0] expect_byte,
	input  logic       active,
	output logic [7:0] byte_out,
	output logic       ok
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	// Compare against the byte this cell holds once the shift completes
	assign ok       = !active || (byte_in == expect_byte);
	assign byte_out = byte_q;

endmodule

// ----- hdl/sfs_tracker.sv -----
// Match position, first/last index and split piece tracking for one text.
`timescale 1ns / 1ps

module sfs_tracker import sfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  trk_ctl_t  ctl,
	output out_item_t res
);

	logic [31:0] pos_q;
	logic        ovf_q;
	logic        seen_q;
	logic [31:0] first_q;
	logic [31:0] last_q;
	logic [32:0] pb_q;
	logic [31:0] pc_q;

	logic [32:0] pos_inc;
	logic        hit, take, cnt_inc, tail;
	logic [31:0] start;
	logic [31:0] pos_n, first_n, last_n, pc_n, pc_out;
	logic        ovf_n, seen_n;
	logic [32:0] pb_n, taken_n;

	always_comb begin
		pos_inc = {1'b0, pos_q} + 33'd1;
		start   = pos_q + 32'd1 - {{(32-LEN_W){1'b0}}, ctl.len};
		hit     = !ovf_q && (ctl.len != '0) && ctl.match &&
			  (pos_inc >= {{(33-LEN_W){1'b0}}, ctl.len});
		take    = hit && ({1'b0, start} >= pb_q);
		cnt_inc = take && (({1'b0, start} > pb_q) || ctl.incl_empty);

		pc_n    = (cnt_inc && pc_q != COUNT_MAX) ? pc_q + 32'd1 : pc_q;
		pb_n    = take ? pos_inc : pb_q;
		seen_n  = seen_q || hit;
		first_n = (hit && !seen_q) ? start : first_q;
		last_n  = hit ? start : last_q;
		pos_n   = ovf_q ? pos_q : pos_inc[31:0];
		ovf_n   = ovf_q || pos_inc[32];

		// Bytes taken so far, 2^32 once saturated
		taken_n = ovf_n ? {1'b1, 32'd0} : {1'b0, pos_n};
		// Open piece after the last delimiter counts only if non-empty and the length is nonzero
		tail    = (ctl.len != '0) && (taken_n > pb_n);
		pc_out  = (tail && pc_n != COUNT_MAX) ? pc_n + 32'd1 : pc_n;

		res.found       = seen_n;
		res.first_index = seen_n ? first_n : '0;
		res.last_index  = seen_n ? last_n : '0;
		res.piece_count = pc_out;
		res.too_long    = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
			pb_q    <= '0;
			pc_q    <= '0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				pos_q   <= '0;
				ovf_q   <= 1'b0;
				seen_q  <= 1'b0;
				first_q <= '0;
				last_q  <= '0;
				pb_q    <= '0;
				pc_q    <= '0;
			end else begin
				pos_q   <= pos_n;
				ovf_q   <= ovf_n;
				seen_q  <= seen_n;
				first_q <= first_n;
				last_q  <= last_n;
				pb_q    <= pb_n;
				pc_q    <= pc_n;
			end
		end
	end

endmodule
